FILE: sv/tournament_branch_predictor_assert.svh
// assertion macros for the tournament branch predictor
`ifndef TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

// same-cycle implication
`define TBP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TBP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/tbp_pkg.sv
package tbp_pkg;

	localparam int INDEX_BITS_DEF = 12;

	localparam logic [1:0]  G_RESET      = 2'd3;
	localparam logic [2:0]  BIM_RESET    = 3'd5;
	localparam logic [2:0]  BIM_MAX      = 3'd5;
	localparam logic [1:0]  CHOOSE_RESET = 2'd3;
	localparam logic [1:0]  TWO_BIT_MAX  = 2'd3;
	localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 72;

	// bimodal and chooser share one entry, indexed by the address
	typedef struct packed {
		logic [1:0] chooser;
		logic [2:0] bimodal;
	} bc_entry_t;

	typedef struct packed {
		logic      pred;
		logic      ok;
		logic      use_b;
		logic [1:0] g_new;
		bc_entry_t bc_new;
	} train_t;

	function automatic logic [1:0] train_two_bit(input logic [1:0] c, input logic t);
		logic [1:0] r;
		if (t) begin
			r = (c != 2'd0) ? c - 2'd1 : 2'd0;
		end else begin
			r = (c != TWO_BIT_MAX) ? c + 2'd1 : TWO_BIT_MAX;
		end
		return r;
	endfunction

	function automatic logic [2:0] train_six_level(input logic [2:0] c, input logic t);
		logic [2:0] r;
		if (t) begin
			r = (c != 3'd0) ? c - 3'd1 : 3'd0;
		end else if (c == 3'd1) begin
			r = 3'd3;
		end else begin
			r = (c < BIM_MAX) ? c + 3'd1 : BIM_MAX;
		end
		return r;
	endfunction

endpackage

FILE: sv/tbp_ram.sv
module tbp_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 2
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/tbp_train.sv
module tbp_train (
	input  logic              taken,
	input  logic [1:0]        g_ctr,
	input  tbp_pkg::bc_entry_t bc,
	output tbp_pkg::train_t   res
);
	import tbp_pkg::*;

	logic g_pred, b_pred, g_ok, b_ok, use_b;
	logic [1:0] ch_new;

	always_comb begin
		g_pred = (g_ctr <= 2'd1);
		b_pred = (bc.bimodal <= 3'd2);
		g_ok   = (g_pred == taken);
		b_ok   = (b_pred == taken);
		use_b  = (bc.chooser >= 2'd2);

		ch_new = bc.chooser;
		if (b_ok && !g_ok && bc.chooser != TWO_BIT_MAX) begin
			ch_new = bc.chooser + 2'd1;
		end else if (g_ok && !b_ok && bc.chooser != 2'd0) begin
			ch_new = bc.chooser - 2'd1;
		end

		res.pred           = use_b ? b_pred : g_pred;
		res.ok             = use_b ? b_ok : g_ok;
		res.use_b          = use_b;
		res.g_new          = train_two_bit(g_ctr, taken);
		res.bc_new.chooser = ch_new;
		res.bc_new.bimodal = train_six_level(bc.bimodal, taken);
	end

endmodule

FILE: sv/tournament_branch_predictor.sv
// a request is held in stage s1 for training, then in the m_axis output register
// throughput: one branch per cycle if not stalled; same-entry updates in a row are forwarded
// the three tables sit in two one-port-read memories read at acceptance, written on s1_go
// after reset a clearing pass writes every entry while s_axis_tready is held low
// history and both totals reset to zero
module tournament_branch_predictor #(
	parameter int INDEX_BITS = tbp_pkg::INDEX_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [31:0] branch_address, [32] taken, rest zero
	input  logic [tbp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [0] predicted_taken, [1] prediction_correct, [2] chose_bimodal,
	// [34:3] correct_total, [66:35] branch_total, rest zero
	output logic [tbp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tbp_pkg::*;

	localparam int BC_W = $bits(bc_entry_t);
	localparam int RES_W = 67;
	localparam int PAD_W = OUT_DATA_W - RES_W;

	logic                  clearing_q;
	logic [INDEX_BITS-1:0] clr_idx_q;
	logic [INDEX_BITS-1:0] hist_q;
	logic [31:0]           branch_cnt_q, correct_cnt_q;

	logic                  valid_s1, taken_s1;
	logic [INDEX_BITS-1:0] ai_s1, gi_s1;
	logic                  g_hit_s1, bc_hit_s1;
	logic [1:0]            g_fwd_s1;
	bc_entry_t             bc_fwd_s1;

	logic                  m_valid_q;
	logic [RES_W-1:0]      m_data_q;

	logic                  in_acc, s1_go;
	logic [INDEX_BITS-1:0] ai_in, gi_in;
	logic                  taken_in;
	logic [1:0]            g_rdata, g_cur;
	logic [BC_W-1:0]       bc_rdata;
	bc_entry_t             bc_cur;
	train_t                trn;
	logic [31:0]           branch_nxt, correct_nxt;

	logic                  g_we, bc_we;
	logic [INDEX_BITS-1:0] g_waddr, bc_waddr;
	logic [1:0]            g_wdata;
	bc_entry_t             bc_wdata;

	assign s1_go         = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !clearing_q && (!valid_s1 || s1_go);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign ai_in    = s_axis_tdata[INDEX_BITS-1:0];
	assign taken_in = s_axis_tdata[32];
	assign gi_in    = ai_in ^ hist_q;

	// clearing pass shares the write port with the update
	always_comb begin
		g_we     = clearing_q || s1_go;
		bc_we    = clearing_q || s1_go;
		g_waddr  = clearing_q ? clr_idx_q : gi_s1;
		bc_waddr = clearing_q ? clr_idx_q : ai_s1;
		g_wdata  = clearing_q ? G_RESET : trn.g_new;
		if (clearing_q) begin
			bc_wdata.chooser = CHOOSE_RESET;
			bc_wdata.bimodal = BIM_RESET;
		end else begin
			bc_wdata = trn.bc_new;
		end
	end

	tbp_ram #(.ADDR_W(INDEX_BITS), .DATA_W(2)) u_gshare_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.re    (in_acc),
		.raddr (gi_in),
		.rdata (g_rdata)
	);

	tbp_ram #(.ADDR_W(INDEX_BITS), .DATA_W(BC_W)) u_bc_ram (
		.clk   (clk),
		.we    (bc_we),
		.waddr (bc_waddr),
		.wdata (bc_wdata),
		.re    (in_acc),
		.raddr (ai_in),
		.rdata (bc_rdata)
	);

	// the entry written at the acceptance edge is not yet in the read data
	assign g_cur  = g_hit_s1 ? g_fwd_s1 : g_rdata;
	assign bc_cur = bc_hit_s1 ? bc_fwd_s1 : bc_entry_t'(bc_rdata);

	tbp_train u_train (
		.taken (taken_s1),
		.g_ctr (g_cur),
		.bc    (bc_cur),
		.res   (trn)
	);

	assign branch_nxt  = (branch_cnt_q == COUNT_MAX) ? branch_cnt_q : branch_cnt_q + 32'd1;
	assign correct_nxt = (trn.ok && correct_cnt_q != COUNT_MAX) ?
		correct_cnt_q + 32'd1 : correct_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q    <= 1'b1;
			clr_idx_q     <= '0;
			hist_q        <= '0;
			branch_cnt_q  <= '0;
			correct_cnt_q <= '0;
			valid_s1      <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + INDEX_BITS'(1);
				if (clr_idx_q == {INDEX_BITS{1'b1}}) begin
					clearing_q <= 1'b0;
				end
			end
			if (in_acc) begin
				hist_q <= {hist_q[INDEX_BITS-2:0], taken_in};
			end
			if (s1_go) begin
				branch_cnt_q  <= branch_nxt;
				correct_cnt_q <= correct_nxt;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ai_s1     <= ai_in;
			gi_s1     <= gi_in;
			taken_s1  <= taken_in;
			// valid_s1 here means the older request writes back at this edge
			g_hit_s1  <= valid_s1 && (gi_s1 == gi_in);
			bc_hit_s1 <= valid_s1 && (ai_s1 == ai_in);
			g_fwd_s1  <= trn.g_new;
			bc_fwd_s1 <= trn.bc_new;
		end
		if (s1_go) begin
			m_data_q <= {branch_nxt, correct_nxt, trn.use_b, trn.ok, trn.pred};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, m_data_q};

	`include "tournament_branch_predictor_assert.svh"

	`TBP_ASSERT_IMP(a_no_accept_clearing, clearing_q, !s_axis_tready,
		"request accepted during clearing pass")
	`TBP_ASSERT_IMP(a_correct_le_total, 1'b1, correct_cnt_q <= branch_cnt_q,
		"correct total exceeds branch total")
	`TBP_ASSERT_NXT(a_total_step, s1_go && branch_cnt_q != COUNT_MAX,
		branch_cnt_q == $past(branch_cnt_q) + 32'd1, "branch total did not advance")

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tbp_pkg::*;

	localparam int IDX_W = 12;
	localparam int TABLE_DEPTH = 1 << IDX_W;
	localparam int RANDOM_ITEMS = 750;
	// the limit outlasts the clearing pass, stalls and gaps are far shorter
	localparam int IDLE_LIMIT = 8 * TABLE_DEPTH;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic        pred;
		logic        ok;
		logic        use_b;
		logic [31:0] correct_total;
		logic [31:0] branch_total;
	} outcome_t;

	typedef struct {
		logic [31:0] addr;
		logic        taken;
		bit          has_known;
		outcome_t    known_outcome;
	} branch_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// shadow copy of the predictor state
	logic [1:0]       gshare_ctr [TABLE_DEPTH];
	logic [2:0]       bimodal_ctr [TABLE_DEPTH];
	logic [1:0]       chooser_ctr [TABLE_DEPTH];
	logic [IDX_W-1:0] ghist;
	logic [31:0]      correct_cnt;
	logic [31:0]      branch_cnt;

	outcome_t    expected_outcomes[$];
	branch_row_t cur_row;
	int          errors;
	int          idle_cycles;
	int          burst_left;

	tournament_branch_predictor #(
		.INDEX_BITS(IDX_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic outcome_t predict_branch(input logic [31:0] addr, input logic t);
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] gi;
		logic             g_pred;
		logic             b_pred;
		logic             g_ok;
		logic             b_ok;
		logic             use_b;
		outcome_t         o;
		a = addr[IDX_W-1:0];
		gi = a ^ ghist;
		g_pred = gshare_ctr[gi] <= 2'd1;
		b_pred = bimodal_ctr[a] <= 3'd2;
		g_ok = (g_pred == t);
		b_ok = (b_pred == t);
		use_b = chooser_ctr[a] >= 2'd2;

		if (t) begin
			if (gshare_ctr[gi] != 2'd0) gshare_ctr[gi] = gshare_ctr[gi] - 2'd1;
			if (bimodal_ctr[a] != 3'd0) bimodal_ctr[a] = bimodal_ctr[a] - 3'd1;
		end else begin
			if (gshare_ctr[gi] != TWO_BIT_MAX) gshare_ctr[gi] = gshare_ctr[gi] + 2'd1;
			// level 1 skips level 2 on not-taken
			if (bimodal_ctr[a] == 3'd1) bimodal_ctr[a] = 3'd3;
			else if (bimodal_ctr[a] < BIM_MAX) bimodal_ctr[a] = bimodal_ctr[a] + 3'd1;
			else bimodal_ctr[a] = BIM_MAX;
		end

		if (b_ok && !g_ok) begin
			if (chooser_ctr[a] != TWO_BIT_MAX) chooser_ctr[a] = chooser_ctr[a] + 2'd1;
		end else if (g_ok && !b_ok) begin
			if (chooser_ctr[a] != 2'd0) chooser_ctr[a] = chooser_ctr[a] - 2'd1;
		end

		ghist = {ghist[IDX_W-2:0], t};
		if (branch_cnt != COUNT_MAX) branch_cnt = branch_cnt + 32'd1;
		if ((use_b ? b_ok : g_ok) && correct_cnt != COUNT_MAX) correct_cnt = correct_cnt + 32'd1;

		o.pred = use_b ? b_pred : g_pred;
		o.ok = use_b ? b_ok : g_ok;
		o.use_b = use_b;
		o.correct_total = correct_cnt;
		o.branch_total = branch_cnt;
		return o;
	endfunction

	function automatic branch_row_t plain_row(input logic [31:0] addr, input logic t);
		branch_row_t r;
		r.addr = addr;
		r.taken = t;
		r.has_known = 1'b0;
		r.known_outcome = '0;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_outcomes.size() == 0) begin
					$display("%0t: result expected none, got %0h", $time, m_axis_tdata);
					errors++;
				end else begin
					want = expected_outcomes.pop_front();
					check_field("predicted_taken", 32'(want.pred), 32'(m_axis_tdata[0]));
					check_field("prediction_correct", 32'(want.ok), 32'(m_axis_tdata[1]));
					check_field("chose_bimodal", 32'(want.use_b), 32'(m_axis_tdata[2]));
					check_field("correct_total", want.correct_total, m_axis_tdata[34:3]);
					check_field("branch_total", want.branch_total, m_axis_tdata[66:35]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = predict_branch(s_axis_tdata[31:0], s_axis_tdata[32]);
				if (cur_row.has_known) want = cur_row.known_outcome;
				expected_outcomes.push_back(want);
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

	// result side stalls on its own schedule
	initial begin
		logic [7:0] stall_bits;
		int         run;
		m_axis_tready = 1'b0;
		forever begin
			run = $urandom_range(8, 64);
			case ($urandom_range(0, 3))
				0: begin
					repeat (run) begin
						@(negedge clk);
						m_axis_tready <= 1'b1;
					end
				end
				1: begin
					stall_bits = 8'($urandom);
					repeat (run) begin
						@(negedge clk);
						m_axis_tready <= stall_bits[0];
						stall_bits = {stall_bits[0], stall_bits[7:1]};
					end
				end
				2: begin
					repeat (run) begin
						@(negedge clk);
						m_axis_tready <= 1'($urandom_range(0, 1));
					end
				end
				default: begin
					repeat (run) begin
						@(negedge clk);
						m_axis_tready <= ($urandom_range(0, 3) == 0);
					end
				end
			endcase
		end
	end

	// entered and left at a falling edge
	task automatic send_branch(input branch_row_t row);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 16);
		end
		cur_row = row;
		s_axis_tdata <= {{(IN_DATA_W-33){1'b0}}, row.taken, row.addr};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (expected_outcomes.size() != 0);
	endtask

	initial begin
		branch_row_t dir_rows[$];
		logic [11:0] pool_lo [8];
		int          pool_bias [8];
		logic [11:0] loop_lo;
		logic [31:0] addr;
		logic        t;
		int          loop_left;
		int          sel;
		int          k;
		int          i;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cur_row = plain_row(32'd0, 1'b0);
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			gshare_ctr[i] = G_RESET;
			bimodal_ctr[i] = BIM_RESET;
			chooser_ctr[i] = CHOOSE_RESET;
		end
		ghist = '0;
		correct_cnt = '0;
		branch_cnt = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fresh tables: bimodal chosen, both components say not taken
		dir_rows.push_back('{32'h0000_0000, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 32'd1, 32'd1}});
		dir_rows.push_back('{32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 32'd1, 32'd2}});
		// high address bits ignored, lands on entry zero again
		dir_rows.push_back('{32'hFFFF_F000, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 32'd2, 32'd3}});
		// walk one bimodal entry down to level 1, then not-taken jumps to level 3
		dir_rows.push_back(plain_row(32'h0000_0155, 1'b1));
		dir_rows.push_back(plain_row(32'h8000_0155, 1'b1));
		dir_rows.push_back(plain_row(32'h7FFF_F155, 1'b1));
		dir_rows.push_back(plain_row(32'hA5A5_A155, 1'b1));
		dir_rows.push_back(plain_row(32'h0000_0155, 1'b0));
		dir_rows.push_back(plain_row(32'h5A5A_5155, 1'b0));
		dir_rows.push_back(plain_row(32'h0000_0155, 1'b1));
		// alternating outcomes then a repeat, gshare sees distinct histories
		dir_rows.push_back(plain_row(32'h0000_02AA, 1'b1));
		dir_rows.push_back(plain_row(32'h0000_02AA, 1'b0));
		dir_rows.push_back(plain_row(32'h0000_02AA, 1'b1));
		dir_rows.push_back(plain_row(32'h0000_02AA, 1'b0));
		dir_rows.push_back(plain_row(32'h0000_02AA, 1'b1));
		dir_rows.push_back(plain_row(32'h0000_02AA, 1'b1));
		dir_rows.push_back(plain_row(32'h0000_0FFF, 1'b1));
		dir_rows.push_back(plain_row(32'h8000_0000, 1'b0));
		dir_rows.push_back(plain_row(32'h7FFF_FFFF, 1'b1));
		dir_rows.push_back(plain_row(32'h0000_0800, 1'b1));
		dir_rows.push_back(plain_row(32'h0000_0001, 1'b0));
		dir_rows.push_back(plain_row(32'hFFFF_FFFE, 1'b1));

		foreach (dir_rows[j]) send_branch(dir_rows[j]);
		drain_results();

		for (k = 0; k < 8; k++) begin
			pool_lo[k] = (k == 0) ? 12'h000 : (k == 1) ? 12'hFFF : 12'($urandom_range(0, 4095));
			pool_bias[k] = $urandom_range(0, 4) * 25;
		end
		loop_lo = 12'($urandom_range(0, 4095));
		loop_left = 0;

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) drain_results();
			sel = $urandom_range(0, 99);
			addr = $urandom;
			if (sel < 55) begin
				// hot branches with a per-branch bias
				k = $urandom_range(0, 7);
				addr[11:0] = pool_lo[k];
				t = ($urandom_range(0, 99) < pool_bias[k]);
			end else if (sel < 80) begin
				// loop branch: taken until the exit iteration
				if (loop_left == 0) loop_left = $urandom_range(2, 9);
				addr[11:0] = loop_lo;
				t = (loop_left != 1);
				loop_left--;
			end else begin
				t = 1'($urandom_range(0, 1));
			end
			send_branch(plain_row(addr, t));
		end
		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0 && expected_outcomes.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/tbp_pkg.sv
sv/tbp_ram.sv
sv/tbp_train.sv
sv/tournament_branch_predictor.sv
tb/sv/tb_top.sv
